[sv/quadrature_position_servo_core_macros.svh]
// assertion macros shared by the servo core modules
// no dependencies; included by the files that carry assertions
`ifndef QUADRATURE_POSITION_SERVO_CORE_MACROS_SVH
`define QUADRATURE_POSITION_SERVO_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define QPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo core check failed");

// next-cycle implication, off during reset
`define QPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo core check failed");

`endif

[sv/qps_pkg.sv]
// shared types, constants and the quadrature step table of the servo core
// no dependencies
package qps_pkg;

    localparam int POSITION_WIDTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH            = 2;
    localparam int POS_OUT_W              = 16;
    localparam int CFG_DATA_W             = 9;
    localparam int CFG_INDEX_W            = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN      = 2'd0,
        CFG_MIN_DRIVE = 2'd1,
        CFG_MAX_DRIVE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [3:0]        gain;
        logic signed [8:0] min_drive;
        logic [7:0]        max_drive;
    } cfg_t;

    localparam logic [3:0]        GAIN_RESET      = 4'd2;
    localparam logic signed [8:0] MIN_DRIVE_RESET = 9'sd10;
    localparam logic [7:0]        MAX_DRIVE_RESET = 8'd255;

    typedef struct packed {
        logic enc_a;
        logic enc_b;
        logic btn_up;
        logic btn_down;
    } sample_t;

    typedef struct packed {
        logic [7:0]                  duty_a;
        logic [7:0]                  duty_b;
        logic signed [POS_OUT_W-1:0] position_now;
    } result_t;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_t;

    // indexed by {new B, new A, old B, old A}
    localparam step_t STEP_TABLE [16] = '{
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE
    };

endpackage

[sv/qps_front.sv]
// front end: takes samples, decodes encoder steps and button releases,
// keeps position and setpoint, forms the error; uses qps_pkg
module qps_front #(
    parameter int POSITION_WIDTH = qps_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      push,
    input  qps_pkg::sample_t                          sample,
    input  logic                                      q_full,
    output logic                                      q_push,
    output logic [POSITION_WIDTH+qps_pkg::POS_OUT_W:0] q_data
);
    import qps_pkg::*;

    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [POSITION_WIDTH-1:0] setpoint_reg, setpoint_next;
    logic [1:0]                last_enc_reg, last_btn_reg;
    logic [1:0]                enc_now, btn_now, falls;
    step_t                     step;
    logic signed [POSITION_WIDTH:0] err;

    assign q_push  = push && !q_full;
    assign enc_now = {sample.enc_b, sample.enc_a};
    assign btn_now = {sample.btn_down, sample.btn_up};
    assign step    = STEP_TABLE[{enc_now, last_enc_reg}];
    assign falls   = last_btn_reg & ~btn_now;

    always_comb
    begin
        unique case (step)
            STEP_UP:   pos_next = pos_reg + 1'b1;
            STEP_DOWN: pos_next = pos_reg - 1'b1;
            default:   pos_next = pos_reg;
        endcase
    end

    // both released together leaves the setpoint alone
    always_comb
    begin
        unique case (falls)
            2'b01:   setpoint_next = setpoint_reg + 1'b1;
            2'b10:   setpoint_next = setpoint_reg - 1'b1;
            default: setpoint_next = setpoint_reg;
        endcase
    end

    assign err = $signed({pos_next[POSITION_WIDTH-1], pos_next})
               - $signed({setpoint_next[POSITION_WIDTH-1], setpoint_next});

    assign q_data = {err, POS_OUT_W'(pos_next)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            setpoint_reg <= '0;
            last_enc_reg <= '0;
            last_btn_reg <= '0;
        end
        else if (q_push)
        begin
            pos_reg      <= pos_next;
            setpoint_reg <= setpoint_next;
            last_enc_reg <= enc_now;
            last_btn_reg <= btn_now;
        end
    end

endmodule

[sv/qps_fifo.sv]
// short request queue between front and back end
// uses qps_pkg for the depth default and the assertion macros header
`include "quadrature_position_servo_core_macros.svh"
module qps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qps_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);
    import qps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_acc, pop_acc;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign push_acc = push && !full;
    assign pop_acc  = pop && !empty;
    assign rd_data  = mem[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        unique case ({push_acc, pop_acc})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_acc)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_acc)
                wr_ptr_reg <= wr_ptr_next;
            if (pop_acc)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    `QPS_ASSERT_NEXT(a_count_up, clk, rst_n, push_acc && !pop_acc, count_reg == $past(count_reg) + 1'b1)
    `QPS_ASSERT_NEXT(a_count_down, clk, rst_n, pop_acc && !push_acc, count_reg == $past(count_reg) - 1'b1)
    `QPS_ASSERT_NEXT(a_lone_entry, clk, rst_n, push_acc && empty, rd_data == $past(wr_data))

endmodule

[sv/qps_back.sv]
// back end: scales the error by the gain, clamps and splits the drive
// into the two duty values; uses qps_pkg and the assertion macros header
`include "quadrature_position_servo_core_macros.svh"
module qps_back #(
    parameter int POSITION_WIDTH = qps_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  qps_pkg::cfg_t                             cfg,
    input  logic                                      q_empty,
    input  logic [POSITION_WIDTH+qps_pkg::POS_OUT_W:0] q_data,
    output logic                                      q_pop,
    output logic                                      empty,
    input  logic                                      pop,
    output qps_pkg::result_t                          result
);
    import qps_pkg::*;

    localparam int ERR_W  = POSITION_WIDTH + 1;
    localparam int PROD_W = ERR_W + 5;

    logic signed [ERR_W-1:0]  err;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic [POS_OUT_W-1:0]     pos_s1_reg;
    logic                     s1_valid_reg, s2_valid_reg;
    logic                     s1_ready, s2_ready;
    logic signed [PROD_W-1:0] hi_ext, lo_ext;
    logic signed [8:0]        drive;
    result_t                  result_next, result_reg;

    assign s2_ready = !s2_valid_reg || pop;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign q_pop    = !q_empty && s1_ready;

    assign err       = $signed(q_data[POS_OUT_W +: ERR_W]);
    assign prod_next = err * $signed({1'b0, cfg.gain});

    assign hi_ext = $signed({{(PROD_W-8){1'b0}}, cfg.max_drive});
    assign lo_ext = $signed({{(PROD_W-9){cfg.min_drive[8]}}, cfg.min_drive});

    // upper clamp wins when the limits cross
    always_comb
    begin
        priority if (prod_reg > hi_ext)
            drive = $signed({1'b0, cfg.max_drive});
        else if (prod_reg < lo_ext)
            drive = cfg.min_drive;
        else
            drive = prod_reg[8:0];
    end

    always_comb
    begin
        result_next.position_now = pos_s1_reg;
        result_next.duty_a       = '0;
        result_next.duty_b       = '0;
        priority if (drive > 9'sd0)
            result_next.duty_b = drive[7:0];
        else if (drive == -9'sd256)
            result_next.duty_a = 8'd255;
        else
            result_next.duty_a = 8'(-drive);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            prod_reg   <= prod_next;
            pos_s1_reg <= q_data[POS_OUT_W-1:0];
        end
        if (s1_valid_reg && s2_ready)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= q_pop;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    assign empty  = !s2_valid_reg;
    assign result = result_reg;

    `QPS_ASSERT_NOW(a_one_side, clk, rst_n, s2_valid_reg, result_reg.duty_a == 8'd0 || result_reg.duty_b == 8'd0)
    `QPS_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s2_ready, s1_valid_reg && $stable(prod_reg))
    `QPS_ASSERT_NEXT(a_s1_load, clk, rst_n, q_pop, s1_valid_reg)

endmodule

[sv/quadrature_position_servo_core.sv]
// path: an accepted sample passes the two-entry request queue, then the
// two-stage back end (gain multiply into the product register, then clamp
// into the result register); one sample per cycle while the receiver pops
// reset: asynchronous active low; position, setpoint and line history clear
// to zero, gain 2, min drive 10, max drive 255, all queues empty
module quadrature_position_servo_core #(
    parameter int POSITION_WIDTH = qps_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  qps_pkg::sample_t                sample,
    output logic                            empty,
    input  logic                            pop,
    output qps_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [qps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [qps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import qps_pkg::*;

    localparam int Q_W = POSITION_WIDTH + 1 + POS_OUT_W;

    cfg_t           cfg_reg;
    logic           q_push, q_full, q_pop, q_empty;
    logic [Q_W-1:0] q_wr_data, q_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain      <= GAIN_RESET;
            cfg_reg.min_drive <= MIN_DRIVE_RESET;
            cfg_reg.max_drive <= MAX_DRIVE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN:      cfg_reg.gain      <= cfg_data[3:0];
                CFG_MIN_DRIVE: cfg_reg.min_drive <= $signed(cfg_data[8:0]);
                CFG_MAX_DRIVE: cfg_reg.max_drive <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    assign full = q_full;

    qps_front #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .sample (sample),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    qps_fifo #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_data (q_rd_data)
    );

    qps_back #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

[tb/sv/quadrature_position_servo_core_tb.sv]
// self-checking testbench for the quadrature position servo core
// depends on qps_pkg and quadrature_position_servo_core
`timescale 1ns / 100ps

module quadrature_position_servo_core_tb;
    import qps_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    sample_t                sample;
    logic                   empty;
    logic                   pop = 1'b0;
    result_t                result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // servo state as this bench sees it
    logic signed [15:0] pos_track;
    logic signed [15:0] setpoint_track;
    logic [1:0]         lines_prev;
    logic [1:0]         buttons_prev;
    logic [3:0]         gain_track;
    logic signed [8:0]  min_drive_track;
    logic [7:0]         max_drive_track;

    result_t predicted_outputs[$];
    sample_t last_sent = '0;
    int      samples_sent = 0;
    int      results_checked = 0;
    int      reg_writes = 0;
    int      mismatches = 0;

    logic [1:0] pop_mode = 2'd0;
    logic [7:0] pop_tick = 8'd0;

    quadrature_position_servo_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // gray code to a 0..3 phase that rises by one per forward step
    function automatic logic [1:0] quad_phase(input logic a, input logic b);
        return {a, a ^ b};
    endfunction

    function automatic sample_t mk_sample(input logic a, input logic b,
                                          input logic up, input logic dn);
        sample_t s;
        s.enc_a    = a;
        s.enc_b    = b;
        s.btn_up   = up;
        s.btn_down = dn;
        return s;
    endfunction

    function result_t servo_step(input sample_t s);
        logic [1:0] moved;
        logic [1:0] released;
        int         err;
        int         drive;
        result_t    r;
        moved = quad_phase(s.enc_a, s.enc_b) - quad_phase(lines_prev[0], lines_prev[1]);
        // a move of two phases is an illegal jump and leaves the count alone
        if (moved == 2'd1)
            pos_track = pos_track + 16'sd1;
        else if (moved == 2'd3)
            pos_track = pos_track - 16'sd1;
        lines_prev = {s.enc_b, s.enc_a};
        released = buttons_prev & ~{s.btn_down, s.btn_up};
        if (released[0])
            setpoint_track = setpoint_track + 16'sd1;
        if (released[1])
            setpoint_track = setpoint_track - 16'sd1;
        buttons_prev = {s.btn_down, s.btn_up};
        err   = int'(pos_track) - int'(setpoint_track);
        drive = err * int'(gain_track);
        // upper limit wins when the limits cross
        if (drive > int'(max_drive_track))
            drive = int'(max_drive_track);
        else if (drive < int'(min_drive_track))
            drive = int'(min_drive_track);
        r = '0;
        if (drive > 0)
            r.duty_b = drive[7:0];
        else
            r.duty_a = (-drive > 255) ? 8'd255 : 8'(-drive);
        r.position_now = pos_track;
        return r;
    endfunction

    // prediction on accepted requests, then comparison of popped results
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            pos_track       = '0;
            setpoint_track  = '0;
            lines_prev      = '0;
            buttons_prev    = '0;
            gain_track      = GAIN_RESET;
            min_drive_track = MIN_DRIVE_RESET;
            max_drive_track = MAX_DRIVE_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                reg_writes++;
                case (cfg_index_t'(cfg_index))
                    CFG_GAIN:      gain_track = cfg_data[3:0];
                    CFG_MIN_DRIVE: min_drive_track = cfg_data;
                    CFG_MAX_DRIVE: max_drive_track = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (push && !full)
                predicted_outputs.push_back(servo_step(sample));
            if (pop && !empty)
            begin
                results_checked++;
                if (predicted_outputs.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no result, actual duty_a %0d duty_b %0d position %0d",
                             $time, result.duty_a, result.duty_b, result.position_now);
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (result.duty_a !== want.duty_a)
                    begin
                        mismatches++;
                        $display("%0t: duty_a expected %0d actual %0d",
                                 $time, want.duty_a, result.duty_a);
                    end
                    if (result.duty_b !== want.duty_b)
                    begin
                        mismatches++;
                        $display("%0t: duty_b expected %0d actual %0d",
                                 $time, want.duty_b, result.duty_b);
                    end
                    if (result.position_now !== want.position_now)
                    begin
                        mismatches++;
                        $display("%0t: position_now expected %0d actual %0d",
                                 $time, want.position_now, result.position_now);
                    end
                end
            end
        end
    end

    // receiver stalls: free running, coin toss, sparse, and on/off blocks from the tick counter
    always @(posedge clk)
    begin
        pop_tick <= pop_tick + 8'd1;
        if (pop_tick[5:0] == 6'd0)
            pop_mode <= 2'($urandom_range(0, 3));
        case (pop_mode)
            2'd0:    pop <= 1'b1;
            2'd1:    pop <= 1'($urandom_range(0, 1));
            2'd2:    pop <= ($urandom_range(0, 7) == 0);
            default: pop <= pop_tick[4];
        endcase
    end

    task automatic send_sample(input sample_t s);
        push   <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        last_sent = s;
        samples_sent++;
    endtask

    task automatic pause(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // first lets the last accepted request be predicted, then waits for the predictions to drain
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_drive(input logic [3:0] g, input logic signed [8:0] lo,
                             input logic [7:0] hi);
        wait_idle();
        write_reg(CFG_GAIN, 9'(g));
        write_reg(CFG_MIN_DRIVE, lo);
        write_reg(CFG_MAX_DRIVE, 9'(hi));
    endtask

    // mostly legal encoder motion with a drift, buttons toggling at given rates
    task automatic run_random(input int count, input logic [1:0] drift,
                              input int up_rate, input int down_rate,
                              input bit drain_midway);
        int         burst;
        int         k;
        sample_t    s;
        logic [1:0] p;
        burst = 0;
        for (k = 0; k < count; k++)
        begin
            if (drain_midway && k == count / 2)
                wait_idle();
            if (burst == 0)
            begin
                burst = $urandom_range(1, 32);
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 12));
            end
            burst--;
            if ($urandom_range(0, 9) < 2)
                s = sample_t'(4'($urandom_range(0, 15)));
            else
            begin
                p = quad_phase(last_sent.enc_a, last_sent.enc_b);
                case ($urandom_range(0, 4))
                    0, 1:    p = p + drift;
                    2:       p = p - drift;
                    default: ;
                endcase
                s.enc_a    = p[1];
                s.enc_b    = p[1] ^ p[0];
                s.btn_up   = last_sent.btn_up ^ ($urandom_range(0, 7) < up_rate);
                s.btn_down = last_sent.btn_down ^ ($urandom_range(0, 7) < down_rate);
            end
            send_sample(s);
        end
    endtask

    task automatic test_encoder_steps();
        // one full forward cycle, two steps back, then illegal jumps and a hold
        send_sample(mk_sample(1'b0, 1'b1, 1'b0, 1'b0));
        send_sample(mk_sample(1'b1, 1'b1, 1'b0, 1'b0));
        send_sample(mk_sample(1'b1, 1'b0, 1'b0, 1'b0));
        send_sample(mk_sample(1'b0, 1'b0, 1'b0, 1'b0));
        send_sample(mk_sample(1'b1, 1'b0, 1'b0, 1'b0));
        send_sample(mk_sample(1'b1, 1'b1, 1'b0, 1'b0));
        send_sample(mk_sample(1'b0, 1'b0, 1'b0, 1'b0));
        send_sample(mk_sample(1'b0, 1'b0, 1'b0, 1'b0));
        send_sample(mk_sample(1'b1, 1'b1, 1'b0, 1'b0));
        send_sample(mk_sample(1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_button_edges();
        send_sample(mk_sample(1'b0, 1'b0, 1'b1, 1'b0));
        send_sample(mk_sample(1'b0, 1'b0, 1'b0, 1'b0));
        send_sample(mk_sample(1'b0, 1'b0, 1'b0, 1'b1));
        send_sample(mk_sample(1'b0, 1'b0, 1'b0, 1'b0));
        // both released together cancel out
        send_sample(mk_sample(1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(mk_sample(1'b0, 1'b0, 1'b0, 1'b0));
        send_sample(mk_sample(1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(mk_sample(1'b0, 1'b0, 1'b1, 1'b0));
        send_sample(mk_sample(1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_default_tracking();
        run_random(200, 2'd1, 1, 3, 1'b0);
    endtask

    task automatic test_drive_limits();
        // setpoint runs away upwards so the drive bottoms out at -256
        set_drive(4'd15, -9'sd256, 8'd255);
        run_random(200, 2'd3, 3, 0, 1'b0);
        set_drive(4'd0, 9'sd0, 8'd0);
        run_random(150, 2'd1, 2, 2, 1'b0);
        set_drive(4'd1, 9'sd255, 8'd255);
        run_random(150, 2'd1, 0, 3, 1'b0);
    endtask

    task automatic test_inverted_clamp();
        set_drive(4'd4, 9'sd200, 8'd50);
        run_random(200, 2'd1, 1, 3, 1'b0);
    endtask

    task automatic test_mixed_traffic();
        set_drive(4'd7, -9'sd255, 8'd255);
        run_random(250, 2'd1, 2, 2, 1'b1);
        set_drive(4'd3, -9'sd100, 8'd100);
        run_random(250, 2'd3, 2, 2, 1'b0);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        sample    = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_GAIN;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encoder_steps();
        test_button_edges();
        test_default_tracking();
        test_drive_limits();
        test_inverted_clamp();
        test_mixed_traffic();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d samples and %0d register writes over seven drive settings",
                 samples_sent, reg_writes);
        $display("%0d results compared, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0 && predicted_outputs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", predicted_outputs.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[quadrature_position_servo_core.f]
+incdir+sv
sv/qps_pkg.sv
sv/qps_front.sv
sv/qps_fifo.sv
sv/qps_back.sv
sv/quadrature_position_servo_core.sv
tb/sv/quadrature_position_servo_core_tb.sv
